### hw/rtl/text_console_writer_unit_defines.svh
// assertion macros for the text console writer
// included by text_console_writer_unit.sv, depends on nothing else
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

`ifndef SYNTH

// check a property on every clock edge outside reset
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check an implication on every clock edge outside reset
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define TCW_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### hw/rtl/tcw_pkg.sv
// shared types and constants of the text console writer
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // fixed field widths
    localparam int CHAR_W    = 8;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CRETURN = 8'h0D;

    // command codes
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_MAP,
        S_ADDR,
        S_CLR,
        S_WR,
        S_RD,
        S_DONE
    } t_state;

    // what the address unit is working for
    typedef enum logic [1:0] {
        PH_CLEAR,
        PH_WRITE,
        PH_READ
    } t_phase;

endpackage

### hw/rtl/text_console_writer_unit.sv
// text console writer: character store, cursor and scroll sequencer
// depends on tcw_pkg and text_console_writer_unit_defines.svh
//
// Usage
//   Input channel i_in_valid / o_in_stall carries one command: a put of
//   i_char_code at the cursor, or a read of the cell at i_read_row,
//   i_read_col. Output channel o_out_valid / i_out_stall returns one
//   transaction per command with the cell character, cursor and scroll flag.
//   One command is worked on at a time; o_in_stall is high while busy.
//   Steps from accept to result valid, with a free output register:
//     carriage return, newline without scroll, out-of-range read: result only
//     ordinary put and in-range read: row map, address multiply, memory
//     a scroll adds a row map, an address multiply and the clear of the new bottom row
//   A new command is taken the cycle after its result is loaded.
//   Scrolling moves a top-row pointer; only the bottom row is rewritten,
//   one cell a cycle. After reset a clearing pass writes spaces to all
//   ROWS * COLUMNS cells, one a cycle, with o_in_stall high.
//   When the receiver stalls, the result holds in the output register and
//   the next command waits in its final state until the register frees.
`timescale 1ns / 1ps

`include "text_console_writer_unit_defines.svh"

module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic [ROW_OUT_W-1:0] i_read_row,
    input  logic [COL_OUT_W-1:0] i_read_col,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CHAR_W-1:0]    o_cell_char,
    output logic [ROW_OUT_W-1:0] o_cursor_row,
    output logic [COL_OUT_W-1:0] o_cursor_col,
    output logic                 o_scrolled
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_END   = COL_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W:0]    ROWS_EXT  = (ROW_W + 1)'(ROWS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);

    // sequencer and cursor state
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [ROW_W-1:0]    r_base,  n_base;
    logic [ROW_W-1:0]    r_row,   n_row;
    logic [COL_W-1:0]    r_col,   n_col;
    logic                r_scr,   n_scr;
    logic                r_pend,  n_pend;
    logic                r_hit,   n_hit;

    // held command and address unit
    logic [CHAR_W-1:0]   r_code,  n_code;
    logic [ROW_W-1:0]    r_rrow,  n_rrow;
    logic [COL_W-1:0]    r_rcol,  n_rcol;
    logic [ROW_W-1:0]    r_prow,  n_prow;
    logic [COL_W-1:0]    r_ucol,  n_ucol;
    logic [ADDR_W-1:0]   r_addr,  n_addr;
    logic [COL_W-1:0]    r_cnt,   n_cnt;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_cell,  n_out_cell;
    logic [ROW_OUT_W-1:0] r_out_row,  n_out_row;
    logic [COL_OUT_W-1:0] r_out_col,  n_out_col;
    logic                r_out_scr,   n_out_scr;

    // character store
    logic [CHAR_W-1:0]   r_mem [CELLS];
    logic [CHAR_W-1:0]   r_rdata;
    logic                mem_we;
    logic [CHAR_W-1:0]   mem_wdata;

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cell_char  = r_out_cell;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;
    assign o_scrolled   = r_out_scr;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_phase     <= PH_WRITE;
            r_base      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_scr       <= 1'b0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_base      <= n_base;
            r_row       <= n_row;
            r_col       <= n_col;
            r_scr       <= n_scr;
            r_pend      <= n_pend;
            r_hit       <= n_hit;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_rrow     <= n_rrow;
        r_rcol     <= n_rcol;
        r_prow     <= n_prow;
        r_ucol     <= n_ucol;
        r_cnt      <= n_cnt;
        r_out_cell <= n_out_cell;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_scr  <= n_out_scr;
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        if (r_state == S_RD) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    // sequencer, cursor update and shared address unit
    always_comb begin
        logic [ROW_W-1:0] lrow;
        logic [COL_W-1:0] lcol;
        logic [ROW_W:0]   psum;
        logic [ROW_W-1:0] base_inc;
        logic             rd_hit;

        n_state     = r_state;
        n_phase     = r_phase;
        n_base      = r_base;
        n_row       = r_row;
        n_col       = r_col;
        n_scr       = r_scr;
        n_pend      = r_pend;
        n_hit       = r_hit;
        n_code      = r_code;
        n_rrow      = r_rrow;
        n_rcol      = r_rcol;
        n_prow      = r_prow;
        n_ucol      = r_ucol;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_cell  = r_out_cell;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_scr   = r_out_scr;
        mem_we      = 1'b0;
        mem_wdata   = CH_BLANK;

        base_inc = (r_base == LAST_ROW) ? '0 : r_base + 1'b1;
        rd_hit   = (32'(i_read_row) < ROWS) && (32'(i_read_col) < COLUMNS);

        // logical to physical row for the address unit
        case (r_phase)
            PH_CLEAR: begin
                lrow = LAST_ROW;
                lcol = '0;
            end
            PH_READ: begin
                lrow = r_rrow;
                lcol = r_rcol;
            end
            default: begin
                lrow = r_row;
                lcol = r_col;
            end
        endcase
        psum = {1'b0, lrow} + {1'b0, r_base};

        // result taken by the receiver
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            // fill the store with spaces after reset
            S_INIT: begin
                mem_we = 1'b1;
                if (r_addr == LAST_CELL) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end

            // take a command and decide the cursor move
            S_IDLE: begin
                if (i_in_valid) begin
                    n_code = i_char_code;
                    n_rrow = ROW_W'(i_read_row);
                    n_rcol = COL_W'(i_read_col);
                    n_hit  = 1'b0;
                    n_scr  = 1'b0;
                    n_pend = 1'b0;
                    if (i_command == CMD_READ) begin
                        n_hit   = rd_hit;
                        n_phase = PH_READ;
                        n_state = rd_hit ? S_MAP : S_DONE;
                    end else if (i_char_code == CH_NEWLINE) begin
                        n_col = '0;
                        if (r_row == LAST_ROW) begin
                            n_base  = base_inc;
                            n_scr   = 1'b1;
                            n_phase = PH_CLEAR;
                            n_state = S_MAP;
                        end else begin
                            n_row   = r_row + 1'b1;
                            n_state = S_DONE;
                        end
                    end else if (i_char_code == CH_CRETURN) begin
                        n_col   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_phase = PH_WRITE;
                        if (r_col == COL_END) begin
                            n_col = '0;
                            if (r_row == LAST_ROW) begin
                                n_base  = base_inc;
                                n_scr   = 1'b1;
                                n_pend  = 1'b1;
                                n_phase = PH_CLEAR;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end
                        n_state = S_MAP;
                    end
                end
            end

            // physical row: logical row plus the top-row pointer, modulo ROWS
            S_MAP: begin
                n_prow  = (psum >= ROWS_EXT) ? ROW_W'(psum - ROWS_EXT) : ROW_W'(psum);
                n_ucol  = lcol;
                n_state = S_ADDR;
            end

            // cell address
            S_ADDR: begin
                n_addr = ADDR_W'(r_prow) * COLS_A + ADDR_W'(r_ucol);
                n_cnt  = '0;
                case (r_phase)
                    PH_CLEAR: n_state = S_CLR;
                    PH_WRITE: n_state = S_WR;
                    PH_READ:  n_state = S_RD;
                    default:  n_state = S_DONE;
                endcase
            end

            // blank the new bottom row
            S_CLR: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST_COL) begin
                    if (r_pend) begin
                        n_phase = PH_WRITE;
                        n_state = S_MAP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            // write the character and advance
            S_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_code;
                n_col     = r_col + 1'b1;
                n_state   = S_DONE;
            end

            // read issued, data registered on this edge
            S_RD: begin
                n_state = S_DONE;
            end

            // load the output register once it is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_cell  = r_hit ? r_rdata : '0;
                    n_out_row   = ROW_OUT_W'(r_row);
                    n_out_col   = COL_OUT_W'(r_col);
                    n_out_scr   = r_scr;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // cursor and pointer stay in range
    `TCW_ASSERT(a_row_range, i_clk, i_rst_n, (r_row <= LAST_ROW) && (r_base <= LAST_ROW), "cursor row or top row out of range")
    `TCW_ASSERT(a_col_range, i_clk, i_rst_n, r_col <= COL_END, "cursor column past wrap position")
    // a character is never written at the wrap position
    `TCW_ASSERT_IMP(a_wr_col, i_clk, i_rst_n, r_state == S_WR, (r_col < COL_END) && (r_phase == PH_WRITE), "write at invalid column")
    // row clearing only for a scroll
    `TCW_ASSERT_IMP(a_clr_scroll, i_clk, i_rst_n, r_state == S_CLR, r_scr && (r_phase == PH_CLEAR), "row clear without scroll")
    // a scrolled result leaves the cursor on the last row
    `TCW_ASSERT_IMP(a_scr_row, i_clk, i_rst_n, o_out_valid && o_scrolled, o_cursor_row == ROW_OUT_W'(ROWS - 1), "scroll left cursor off last row")

endmodule

### verif/tb_text_console_writer_unit.sv
// testbench for text_console_writer_unit: directed table, then random text, newlines and reads
// untyped replies predicted from a shadow screen and cursor; depends on tcw_pkg and block RTL
`timescale 1ns / 1ps

module tb_text_console_writer_unit
    import tcw_pkg::*;
();

    localparam int SCREEN_COLS   = COLUMNS_DEF;
    localparam int SCREEN_ROWS   = ROWS_DEF;
    localparam int SCREEN_CELLS  = SCREEN_COLS * SCREEN_ROWS;
    localparam int DIRECTED_LEN  = 21;
    localparam int RANDOM_ITEMS  = 600;
    localparam int CALM_TAIL     = 60;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PRINT_CAP     = 40;

    // one reply transaction as the block returns it
    typedef struct packed {
        logic [CHAR_W-1:0]    cell_char;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
        logic                 scrolled;
    } t_console_reply;

    // one row of the directed table; typed rows carry their reply
    typedef struct packed {
        logic                 cmd;
        logic [CHAR_W-1:0]    code;
        logic [ROW_OUT_W-1:0] rrow;
        logic [COL_OUT_W-1:0] rcol;
        logic                 typed;
        t_console_reply       want;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_command;
    logic [CHAR_W-1:0]    i_char_code;
    logic [ROW_OUT_W-1:0] i_read_row;
    logic [COL_OUT_W-1:0] i_read_col;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [CHAR_W-1:0]    o_cell_char;
    logic [ROW_OUT_W-1:0] o_cursor_row;
    logic [COL_OUT_W-1:0] o_cursor_col;
    logic                 o_scrolled;

    // shadow of the screen store and cursor
    logic [CHAR_W-1:0] shadow_screen [SCREEN_CELLS];
    int                shadow_row;
    int                shadow_col;

    t_console_reply awaited_replies [$];
    t_stim_row      directed_rows [DIRECTED_LEN];

    int accepted;
    int replies_seen;
    int read_count;
    int scroll_count;
    int wrap_count;
    int fail_count;
    int cycle_count;
    int stall_left;
    bit calm;
    bit sender_gappy;

    text_console_writer_unit #(
        .COLUMNS(SCREEN_COLS),
        .ROWS   (SCREEN_ROWS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cell_char (o_cell_char),
        .o_cursor_row(o_cursor_row),
        .o_cursor_col(o_cursor_col),
        .o_scrolled  (o_scrolled)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // move the shadow screen up one row and blank the bottom row
    function automatic void scroll_shadow();
        for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++) begin
            shadow_screen[i] = shadow_screen[i + SCREEN_COLS];
        end
        for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++) begin
            shadow_screen[i] = CH_BLANK;
        end
        scroll_count++;
    endfunction

    // apply one command to the shadow console and work out its reply
    function automatic t_console_reply advance_console(
        input logic                 cmd,
        input logic [CHAR_W-1:0]    code,
        input logic [ROW_OUT_W-1:0] rrow,
        input logic [COL_OUT_W-1:0] rcol
    );
        t_console_reply reply;
        reply = '0;
        if (cmd == CMD_READ) begin
            read_count++;
            if (rrow < SCREEN_ROWS && rcol < SCREEN_COLS) begin
                reply.cell_char = shadow_screen[rrow * SCREEN_COLS + rcol];
            end
        end else if (code == CH_NEWLINE) begin
            // pending wrap is dropped, bottom row scrolls
            if (shadow_row == SCREEN_ROWS - 1) begin
                scroll_shadow();
                reply.scrolled = 1'b1;
            end else begin
                shadow_row++;
            end
            shadow_col = 0;
        end else if (code == CH_CRETURN) begin
            shadow_col = 0;
        end else begin
            // pending wrap resolves before the write
            if (shadow_col >= SCREEN_COLS) begin
                shadow_col = 0;
                wrap_count++;
                if (shadow_row == SCREEN_ROWS - 1) begin
                    scroll_shadow();
                    reply.scrolled = 1'b1;
                end else begin
                    shadow_row++;
                end
            end
            shadow_screen[shadow_row * SCREEN_COLS + shadow_col] = code;
            shadow_col++;
        end
        reply.cursor_row = ROW_OUT_W'(shadow_row);
        reply.cursor_col = COL_OUT_W'(shadow_col);
        return reply;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= PRINT_CAP) begin
            $display("mismatch on reply %0d, %s: got %0d, want %0d", replies_seen, what, got, want);
        end
    endtask

    // send one command transaction and queue its reply
    task automatic issue_command(
        input logic                 cmd,
        input logic [CHAR_W-1:0]    code,
        input logic [ROW_OUT_W-1:0] rrow,
        input logic [COL_OUT_W-1:0] rcol,
        input logic                 typed,
        input t_console_reply       want
    );
        t_console_reply predicted;
        // no idling in the closing stretch
        if (accepted >= DIRECTED_LEN + RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;
        if (!calm && sender_gappy && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_char_code <= code;
        i_read_row  <= rrow;
        i_read_col  <= rcol;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = advance_console(cmd, code, rrow, rcol);
        awaited_replies.push_back(typed ? want : predicted);
        accepted++;
    endtask

    task automatic issue_put(input logic [CHAR_W-1:0] code);
        issue_command(CMD_PUT, code, ROW_OUT_W'($urandom_range(0, 31)),
                      COL_OUT_W'($urandom_range(0, 127)), 1'b0, '0);
    endtask

    // hold off the sender until every reply is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_replies.size() != 0);
    endtask

    // reply checking and receiver stall bursts
    always @(posedge i_clk) begin
        t_console_reply want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (awaited_replies.size() == 0) begin
                report_mismatch("unrequested reply", 1, 0);
            end else begin
                want = awaited_replies.pop_front();
                if (o_cell_char !== want.cell_char)
                    report_mismatch("cell_char", int'(o_cell_char), int'(want.cell_char));
                if (o_cursor_row !== want.cursor_row)
                    report_mismatch("cursor_row", int'(o_cursor_row), int'(want.cursor_row));
                if (o_cursor_col !== want.cursor_col)
                    report_mismatch("cursor_col", int'(o_cursor_col), int'(want.cursor_col));
                if (o_scrolled !== want.scrolled)
                    report_mismatch("scrolled", int'(o_scrolled), int'(want.scrolled));
            end
            replies_seen++;
        end
        if (calm) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else if ($urandom_range(0, 2) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 12);
        end else begin
            i_out_stall <= 1'b0;
            stall_left = $urandom_range(0, 39);
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("no end of run after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    // stimulus
    initial begin
        int pick;
        int len;
        int ending;
        int mode;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = CMD_PUT;
        i_char_code = '0;
        i_read_row  = '0;
        i_read_col  = '0;
        calm         = 1'b0;
        sender_gappy = 1'b1;
        for (int i = 0; i < SCREEN_CELLS; i++) shadow_screen[i] = CH_BLANK;
        shadow_row = 0;
        shadow_col = 0;

        // cmd, code, read row, read col, typed, reply
        directed_rows = '{
            '{CMD_READ, 8'h00, 5'd0,  7'd0,   1'b1, '{CH_BLANK, 5'd0, 7'd0, 1'b0}},
            '{CMD_READ, 8'h00, 5'd24, 7'd79,  1'b1, '{CH_BLANK, 5'd0, 7'd0, 1'b0}},
            '{CMD_READ, 8'h00, 5'd25, 7'd0,   1'b1, '{8'h00, 5'd0, 7'd0, 1'b0}},
            '{CMD_READ, 8'h00, 5'd0,  7'd80,  1'b1, '{8'h00, 5'd0, 7'd0, 1'b0}},
            '{CMD_READ, 8'hFF, 5'd31, 7'd127, 1'b1, '{8'h00, 5'd0, 7'd0, 1'b0}},
            '{CMD_PUT,  8'h41, 5'd0,  7'd0,   1'b1, '{8'h00, 5'd0, 7'd1, 1'b0}},
            '{CMD_PUT,  8'hFF, 5'd0,  7'd0,   1'b1, '{8'h00, 5'd0, 7'd2, 1'b0}},
            '{CMD_PUT,  8'h00, 5'd0,  7'd0,   1'b1, '{8'h00, 5'd0, 7'd3, 1'b0}},
            '{CMD_READ, 8'h00, 5'd0,  7'd0,   1'b1, '{8'h41, 5'd0, 7'd3, 1'b0}},
            '{CMD_READ, 8'h00, 5'd0,  7'd2,   1'b1, '{8'h00, 5'd0, 7'd3, 1'b0}},
            '{CMD_PUT,  CH_CRETURN, 5'd0, 7'd0, 1'b1, '{8'h00, 5'd0, 7'd0, 1'b0}},
            '{CMD_PUT,  8'h42, 5'd0,  7'd0,   1'b1, '{8'h00, 5'd0, 7'd1, 1'b0}},
            '{CMD_READ, 8'h00, 5'd0,  7'd0,   1'b1, '{8'h42, 5'd0, 7'd1, 1'b0}},
            '{CMD_PUT,  CH_NEWLINE, 5'd0, 7'd0, 1'b1, '{8'h00, 5'd1, 7'd0, 1'b0}},
            '{CMD_PUT,  CH_CRETURN, 5'd0, 7'd0, 1'b1, '{8'h00, 5'd1, 7'd0, 1'b0}},
            '{CMD_PUT,  8'h7E, 5'd31, 7'd127, 1'b1, '{8'h00, 5'd1, 7'd1, 1'b0}},
            '{CMD_READ, 8'h00, 5'd1,  7'd0,   1'b1, '{8'h7E, 5'd1, 7'd1, 1'b0}},
            '{CMD_READ, 8'h00, 5'd0,  7'd1,   1'b1, '{8'hFF, 5'd1, 7'd1, 1'b0}},
            '{CMD_PUT,  CH_NEWLINE, 5'd0, 7'd0, 1'b1, '{8'h00, 5'd2, 7'd0, 1'b0}},
            '{CMD_READ, 8'h00, 5'd0,  7'd2,   1'b0, '0},
            '{CMD_PUT,  8'h80, 5'd0,  7'd0,   1'b0, '0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i]) begin
            issue_command(directed_rows[i].cmd, directed_rows[i].code, directed_rows[i].rrow,
                          directed_rows[i].rcol, directed_rows[i].typed, directed_rows[i].want);
        end
        wait_drained();

        // random segments: text lines, newline runs, reads, noise, drains
        while (accepted < DIRECTED_LEN + RANDOM_ITEMS) begin
            sender_gappy = ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // line of text, sometimes exactly full or overrunning
                mode = $urandom_range(0, 9);
                if (mode < 5) len = $urandom_range(0, 8);
                else if (mode < 8) len = $urandom_range(9, SCREEN_COLS - 2);
                else len = $urandom_range(SCREEN_COLS - 1, SCREEN_COLS + 2);
                for (int k = 0; k < len; k++) begin
                    issue_put(CHAR_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                                  : $urandom_range(8'h20, 8'h7E)));
                end
                ending = $urandom_range(0, 19);
                if (ending < 10) begin
                    issue_put(CH_NEWLINE);
                end else if (ending < 13) begin
                    issue_put(CH_CRETURN);
                end else if (ending < 16) begin
                    issue_put(CH_CRETURN);
                    issue_put(CH_NEWLINE);
                end
            end else if (pick < 60) begin
                // run of newlines, each scrolls once the cursor is on the bottom row
                repeat ($urandom_range(1, 30)) issue_put(CH_NEWLINE);
            end else if (pick < 82) begin
                // reads, mostly in range, some on the cursor row
                repeat ($urandom_range(1, 6)) begin
                    mode = $urandom_range(0, 9);
                    if (mode < 2) begin
                        issue_command(CMD_READ, CHAR_W'($urandom_range(0, 255)),
                                      ROW_OUT_W'($urandom_range(0, 31)),
                                      COL_OUT_W'($urandom_range(0, 127)), 1'b0, '0);
                    end else if (mode < 5) begin
                        issue_command(CMD_READ, CHAR_W'($urandom_range(0, 255)),
                                      ROW_OUT_W'(shadow_row),
                                      COL_OUT_W'($urandom_range(0, SCREEN_COLS)), 1'b0, '0);
                    end else begin
                        issue_command(CMD_READ, CHAR_W'($urandom_range(0, 255)),
                                      ROW_OUT_W'($urandom_range(0, SCREEN_ROWS - 1)),
                                      COL_OUT_W'($urandom_range(0, SCREEN_COLS - 1)), 1'b0, '0);
                    end
                end
            end else if (pick < 95) begin
                // fully random transactions
                repeat ($urandom_range(1, 4)) begin
                    issue_command(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                                  ROW_OUT_W'($urandom_range(0, 31)),
                                  COL_OUT_W'($urandom_range(0, 127)), 1'b0, '0);
                end
            end else begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d commands (%0d reads), %0d scrolls, %0d line wraps, %0d mismatches",
                 accepted, read_count, scroll_count, wrap_count, fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
